@@ hw/rtl/nlms_pkg.sv @@
// Shared constants and controller/datapath interface types for the NLMS filter.
`default_nettype none
package nlms_pkg;

  localparam int DEF_NUM_TAPS = 32;
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 32;
  localparam int ENERGY_W     = 40;
  localparam int STEP_W       = 16;
  localparam int TAPS_CFG_W   = 6;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int MAG_W        = 32;
  localparam int DVD_W        = MAG_W + 30;
  localparam int W_W          = 49;
  localparam int DIV_CNT_W    = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAPS_IN_USE = 8'd1;

  localparam logic [STEP_W-1:0]     STEP_RESET = 16'd8192;
  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 6'd32;

  typedef struct packed {
    logic load_in;
    logic upd_energy;
    logic fir_mac;
    logic fir_flush;
    logic calc_y;
    logic calc_e;
    logic div_step;
    logic calc_w;
    logic upd_mul;
    logic upd_add;
    logic finish;
  } nlms_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic div_last;
    logic out_free;
  } nlms_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/nlms_ctrl.sv @@
// Sequencer for one NLMS item: energy, FIR pass, division, coefficient pass.
`default_nettype none
module nlms_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_fire,
  output logic                   in_idle,
  input  nlms_pkg::nlms_status_t status,
  output nlms_pkg::nlms_cmd_t    cmd
);
  import nlms_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_ENERGY = 12'b000000000010,
    S_FIR    = 12'b000000000100,
    S_FLUSH  = 12'b000000001000,
    S_Y      = 12'b000000010000,
    S_E      = 12'b000000100000,
    S_DIV    = 12'b000001000000,
    S_W      = 12'b000010000000,
    S_MUL    = 12'b000100000000,
    S_ADD    = 12'b001000000000,
    S_DONE   = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          state_next  = S_ENERGY;
        end
      end
      S_ENERGY: begin
        cmd.upd_energy = 1'b1;
        state_next     = S_FIR;
      end
      S_FIR: begin
        cmd.fir_mac = 1'b1;
        if (status.last_tap) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.fir_flush = 1'b1;
        state_next    = S_Y;
      end
      S_Y: begin
        cmd.calc_y = 1'b1;
        state_next = S_E;
      end
      S_E: begin
        cmd.calc_e = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_W;
      end
      S_W: begin
        cmd.calc_w = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.upd_mul = 1'b1;
        state_next  = S_ADD;
      end
      S_ADD: begin
        cmd.upd_add = 1'b1;
        state_next  = status.last_tap ? S_DONE : S_MUL;
      end
      S_DONE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_idle = (state == S_IDLE);

endmodule
`default_nettype wire

@@ hw/rtl/nlms_dp.sv @@
// Datapath: delay line, coefficients, energy, MAC, serial divider, output register.
`default_nettype none
module nlms_dp #(
  parameter int NUM_TAPS = nlms_pkg::DEF_NUM_TAPS
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  nlms_pkg::nlms_cmd_t                 cmd,
  output nlms_pkg::nlms_status_t              status,
  input  wire signed [nlms_pkg::SAMPLE_W-1:0] sample_in,
  input  wire signed [nlms_pkg::SAMPLE_W-1:0] reference_in,
  input  wire        [nlms_pkg::STEP_W-1:0]   step_size,
  input  wire        [nlms_pkg::TAPS_CFG_W-1:0] taps_in_use,
  output logic signed [nlms_pkg::SAMPLE_W-1:0] filtered_out,
  output logic signed [nlms_pkg::SAMPLE_W-1:0] error_out,
  output logic                                out_valid,
  input  wire                                 out_ready
);
  import nlms_pkg::*;

  localparam int IDX_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int CNT_W = $clog2(NUM_TAPS + 1) + 1;
  localparam int ACC_W = SAMPLE_W + COEF_W + CNT_W;
  localparam int SH_W  = ACC_W - 30;

  logic signed [SAMPLE_W-1:0] dline [NUM_TAPS];
  logic signed [COEF_W-1:0]   coef  [NUM_TAPS];
  logic        [ENERGY_W-1:0] energy;
  logic signed [SAMPLE_W-1:0] leave;
  logic signed [SAMPLE_W-1:0] ref_q;
  logic        [MAG_W-1:0]    sq_old, sq_new;
  logic [IDX_W-1:0]           k;
  logic signed [SAMPLE_W+COEF_W-1:0] prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] y_q, e_q;
  logic        [ENERGY_W:0]   rem;
  logic        [DVD_W-1:0]    dvd;
  logic [DIV_CNT_W-1:0]       div_cnt;
  logic signed [W_W-1:0]      w;
  logic signed [48:0]         plo;
  logic signed [32:0]         phi;

  // effective tap count
  logic [CNT_W-1:0] taps_ext, taps_eff, last_idx;
  always_comb begin
    taps_ext = CNT_W'(taps_in_use);
    if (taps_ext == '0) taps_eff = CNT_W'(1);
    else if (taps_ext > CNT_W'(NUM_TAPS)) taps_eff = CNT_W'(NUM_TAPS);
    else taps_eff = taps_ext;
    last_idx = taps_eff - CNT_W'(1);
  end

  // energy update
  logic [ENERGY_W-1:0] e_diff;
  logic [ENERGY_W:0]   e_sum;
  always_comb begin
    e_diff = (energy >= ENERGY_W'(sq_old)) ? energy - ENERGY_W'(sq_old) : '0;
    e_sum  = {1'b0, e_diff} + (ENERGY_W+1)'(sq_new);
  end

  // output rounding
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [SH_W-1:0]  y_sh;
  logic signed [SAMPLE_W-1:0] y_sat;
  always_comb begin
    acc_rnd = acc + (ACC_W'(1) <<< 29);
    y_sh    = SH_W'(acc_rnd >>> 30);
    if (y_sh > SH_W'(32767)) y_sat = 16'sh7FFF;
    else if (y_sh < -SH_W'(32768)) y_sat = -16'sh8000;
    else y_sat = SAMPLE_W'(y_sh);
  end

  // error and step magnitude
  logic signed [SAMPLE_W:0]   e_wide;
  logic signed [SAMPLE_W-1:0] e_sat;
  logic        [SAMPLE_W-1:0] e_abs;
  always_comb begin
    e_wide = {ref_q[SAMPLE_W-1], ref_q} - {y_q[SAMPLE_W-1], y_q};
    if (e_wide > 17'sd32767) e_sat = 16'sh7FFF;
    else if (e_wide < -17'sd32768) e_sat = -16'sh8000;
    else e_sat = SAMPLE_W'(e_wide);
    e_abs = e_sat[SAMPLE_W-1] ? SAMPLE_W'(-{e_sat[SAMPLE_W-1], e_sat}) : e_sat;
  end

  // restoring divider step
  logic [ENERGY_W:0]   den;
  logic [ENERGY_W+1:0] trial;
  logic                qbit;
  always_comb begin
    den   = {1'b0, energy} + (ENERGY_W+1)'(128);
    trial = {rem, dvd[DVD_W-1]};
    qbit  = (trial >= {1'b0, den});
  end

  // step weight with clamp
  logic [W_W-1:0] num_c;
  always_comb begin
    if (dvd > DVD_W'(64'h8000_0000_0000)) num_c = W_W'(49'h8000_0000_0000);
    else num_c = W_W'(dvd);
  end

  // coefficient update
  logic signed [65:0] upd_full;
  logic signed [50:0] delta;
  logic signed [51:0] c_sum;
  logic signed [COEF_W-1:0] c_sat;
  always_comb begin
    upd_full = ({{33{phi[32]}}, phi} <<< 32) + {{17{plo[48]}}, plo} + 66'sd16384;
    delta    = 51'(upd_full >>> 15);
    c_sum    = {{20{coef[k][COEF_W-1]}}, coef[k]} + {delta[50], delta};
    if (c_sum > 52'sh7FFF_FFFF) c_sat = 32'sh7FFF_FFFF;
    else if (c_sum < -52'sh8000_0000) c_sat = -32'sh8000_0000;
    else c_sat = COEF_W'(c_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        dline[i] <= '0;
        coef[i]  <= '0;
      end
      energy    <= '0;
      leave     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load_in) begin
        for (int i = NUM_TAPS - 1; i > 0; i--) dline[i] <= dline[i-1];
        dline[0] <= sample_in;
        ref_q    <= reference_in;
        sq_old   <= MAG_W'(leave * leave);
        sq_new   <= MAG_W'(sample_in * sample_in);
      end
      if (cmd.upd_energy) begin
        energy <= e_sum[ENERGY_W] ? '1 : e_sum[ENERGY_W-1:0];
        k      <= '0;
        acc    <= '0;
        prod   <= '0;
      end
      if (cmd.fir_mac) begin
        acc  <= acc + ACC_W'(prod);
        prod <= dline[k] * coef[k];
        k    <= k + IDX_W'(1);
      end
      if (cmd.fir_flush) acc <= acc + ACC_W'(prod);
      if (cmd.calc_y) y_q <= y_sat;
      if (cmd.calc_e) begin
        e_q     <= e_sat;
        rem     <= '0;
        dvd     <= {MAG_W'(e_abs) * MAG_W'(step_size), 30'b0};
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        rem     <= qbit ? (ENERGY_W+1)'(trial - {1'b0, den}) : trial[ENERGY_W:0];
        dvd     <= {dvd[DVD_W-2:0], qbit};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.calc_w) begin
        w <= e_q[SAMPLE_W-1] ? -$signed(num_c) : $signed(num_c);
        k <= '0;
      end
      if (cmd.upd_mul) begin
        plo <= $signed({1'b0, w[31:0]}) * dline[k];
        phi <= $signed(w[48:32]) * dline[k];
      end
      if (cmd.upd_add) begin
        coef[k] <= c_sat;
        k       <= k + IDX_W'(1);
      end
      if (cmd.finish) begin
        leave        <= dline[last_idx[IDX_W-1:0]];
        filtered_out <= y_q;
        error_out    <= e_q;
      end
    end
  end

  assign status.last_tap = (k == last_idx[IDX_W-1:0]);
  assign status.div_last = (div_cnt == DIV_CNT_W'(DVD_W - 1));
  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

@@ hw/rtl/nlms_adaptive_fir.sv @@
// Normalised LMS adaptive FIR filter, top level.
//
// Input stream s_axis: one item = one sample and one reference, both Q1.15.
// Output stream m_axis: one item per input = filter output and error, Q1.15.
// Configuration channel cfg: index 0 writes step_size, index 1 taps_in_use;
// other indexes are ignored. Write only while the block is idle.
// After acceptance, an item goes through a FIR pass of one MAC per active tap,
// a restoring divider giving one quotient bit per cycle over 62 bits, and a
// coefficient pass that for each tap does a split wide multiply, then an add
// and saturate.
// Items are processed one at a time; s_axis_tready is high only when idle,
// so a new item is taken only once the previous one has finished.
// The result sits in an output register; the next item is taken while it
// waits. When the receiver stalls for longer, the sequencer holds its
// finished result until the register frees.
// Reset (synchronous, active high) clears delay line, coefficients, energy
// and the output valid flag, and loads step_size and taps_in_use defaults.
`default_nettype none
module nlms_adaptive_fir #(
  parameter int NUM_TAPS = nlms_pkg::DEF_NUM_TAPS
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // sample_in[15:0], reference_in[31:16]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // filtered_out[15:0], error_out[31:16]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [nlms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [nlms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nlms_pkg::*;

  logic [STEP_W-1:0]     step_size;
  logic [TAPS_CFG_W-1:0] taps_in_use;
  nlms_cmd_t    cmd;
  nlms_status_t status;
  logic         in_idle;
  logic signed [SAMPLE_W-1:0] filtered_out, error_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= STEP_RESET;
      taps_in_use <= TAPS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STEP_SIZE) step_size <= cfg_data;
      else if (cfg_index == REG_TAPS_IN_USE) taps_in_use <= cfg_data[TAPS_CFG_W-1:0];
    end
  end

  assign s_axis_tready = in_idle;

  nlms_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (s_axis_tvalid && in_idle),
    .in_idle (in_idle),
    .status  (status),
    .cmd     (cmd)
  );

  nlms_dp #(.NUM_TAPS(NUM_TAPS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_in    (s_axis_tdata[15:0]),
    .reference_in (s_axis_tdata[31:16]),
    .step_size    (step_size),
    .taps_in_use  (taps_in_use),
    .filtered_out (filtered_out),
    .error_out    (error_out),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready)
  );

  assign m_axis_tdata = {error_out, filtered_out};

endmodule
`default_nettype wire
